FILE: rtl/core/chte_pkg.sv
`timescale 1ns / 1ps
package chte_pkg;

   localparam int NumBucketsDefault = 256;
   localparam int NumNodesDefault   = 1024;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_FIND   = 2'd1,
      OP_DELETE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DUP      = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   localparam logic CSR_BUCKET_COUNT     = 1'b0;
   localparam logic CSR_ALLOW_DUPLICATES = 1'b1;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] key;
      logic [31:0] data;
      logic        match_data;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  bucket;
      logic [31:0] found_data;
      logic [10:0] removed_count;
      logic [10:0] entry_count;
   } rsp_type;

endpackage

FILE: rtl/core/chained_hash_table_engine_top.sv
`timescale 1ns / 1ps
// chained hash table engine
// req channel: one transaction per operation (insert, find, delete) with
//   key, data and match_data; accepted when req_valid is high and req_stall low.
// rsp channel: exactly one result transaction per request, in order.
// csr channel: valid/ready write of bucket_count (index 0) or
//   allow_duplicates (index 1); write only while the engine is idle.
// the bucket index comes from a restoring divider, one quotient bit per cycle;
//   then the chain walk reads each node visited from the single-port node
//   memory, with setup and link update states around it.
// the engine works on one transaction at a time; req_stall is high from
//   acceptance until the result has been taken by the receiver.
// reset: all chains empty, entry count zero. the free list is built by a
//   sweep over all NUM_NODES nodes after reset, during which req_stall stays high.
// receiver stall: the result stays on rsp_* unchanged while rsp_stall is high.
module chained_hash_table_engine_top #(
   parameter int NUM_BUCKETS = chte_pkg::NumBucketsDefault,
   parameter int NUM_NODES   = chte_pkg::NumNodesDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  chte_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output chte_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [0:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   import chte_pkg::*;

   localparam int NW = $clog2(NUM_NODES);
   localparam int BW = $clog2(NUM_BUCKETS);
   localparam int CW = $clog2(NUM_NODES + 1);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_DIV, S_HEAD, S_RD, S_CHK, S_WRN, S_WRP, S_FREE, S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [8:0]  bcount_ff;
   logic        allow_dup_ff;
   logic [NW-1:0] heads_mem [NUM_BUCKETS];
   logic [NUM_BUCKETS-1:0] head_valid_ff;
   logic [31:0] key_mem [NUM_NODES];
   logic [31:0] val_mem [NUM_NODES];
   logic [NW:0] link_mem [NUM_NODES];   // msb is the valid bit

   req_type req_ff;
   logic [31:0] rem_ff, quo_ff;
   logic [5:0]  step_ff;
   logic [BW-1:0] h_ff;
   logic [NW-1:0] free_head_ff;
   logic        free_valid_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] removed_ff;
   logic [NW-1:0] cur_ff, prev_ff, nd_ff;
   logic        have_cur_ff, have_prev_ff;
   logic [31:0] rd_key_ff, rd_val_ff;
   logic [NW:0] rd_link_ff;
   logic [NW:0] head_rd_ff;
   logic [1:0]  status_ff;
   logic [31:0] found_ff;
   logic        rsp_valid_ff;
   logic [NW-1:0] init_ff;
   logic [CW-1:0] guard_ff;

   // memory port signals
   logic          nwe;
   logic [NW-1:0] naddr;
   logic [NW:0]   nlink_wd;
   logic          kv_we;
   logic          hwe;
   logic [NW:0]   hwd;

   logic [8:0]  eff_n;
   logic [32:0] trial;
   logic        key_hit, dmatch;

   always_comb begin
      eff_n = bcount_ff;
      if (bcount_ff == 9'd0) eff_n = 9'd2;
      if ({23'd0, bcount_ff} > NUM_BUCKETS) eff_n = 9'(NUM_BUCKETS);
   end

   assign trial   = {rem_ff, quo_ff[31]} - {24'd0, eff_n};
   assign key_hit = rd_key_ff == req_ff.key;
   assign dmatch  = !req_ff.match_data || (rd_val_ff == req_ff.data);

   // memories
   always_ff @(posedge clock) begin
      if (nwe) link_mem[naddr] <= nlink_wd;
      if (kv_we) begin
         key_mem[naddr] <= req_ff.key;
         val_mem[naddr] <= req_ff.data;
      end
      rd_link_ff <= link_mem[naddr];
      rd_key_ff  <= key_mem[naddr];
      rd_val_ff  <= val_mem[naddr];
      if (hwe) heads_mem[h_ff] <= hwd[NW-1:0];
      head_rd_ff <= {head_valid_ff[h_ff], heads_mem[h_ff]};
   end

   always_comb begin
      state_in = state_ff;
      nwe = 1'b0; kv_we = 1'b0; hwe = 1'b0;
      naddr = cur_ff; nlink_wd = '0; hwd = '0;
      case (state_ff)
         S_INIT: begin
            naddr = init_ff;
            nwe = 1'b1;
            nlink_wd = {(32'(init_ff) + 1) < NUM_NODES, NW'(32'(init_ff) + 1)};
         end
         S_WRN: begin
            naddr = nd_ff;
            nwe = 1'b1;
            kv_we = (req_ff.operation == OP_INSERT);
            if (req_ff.operation == OP_INSERT && allow_dup_ff)
               nlink_wd = head_rd_ff;
            else
               nlink_wd = {have_cur_ff, cur_ff};
            if (req_ff.operation == OP_DELETE) begin
               kv_we = 1'b0;
               nlink_wd = {free_valid_ff, free_head_ff};
            end
         end
         S_WRP: begin
            if (have_prev_ff) begin
               naddr = prev_ff;
               nwe = 1'b1;
               nlink_wd = (req_ff.operation == OP_DELETE) ? rd_link_ff : {1'b1, nd_ff};
            end else begin
               hwe = 1'b1;
               hwd = (req_ff.operation == OP_DELETE) ? rd_link_ff : {1'b1, nd_ff};
            end
         end
         S_FREE: begin
            naddr = nd_ff;
            nwe = 1'b1;
            nlink_wd = {free_valid_ff, free_head_ff};
         end
         S_HEAD, S_CHK: naddr = free_head_ff;
         default: naddr = cur_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         bcount_ff     <= 9'd2;
         allow_dup_ff  <= 1'b0;
         head_valid_ff <= '0;
         free_head_ff  <= '0;
         free_valid_ff <= 1'b1;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         init_ff       <= '0;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_BUCKET_COUNT) bcount_ff <= csr_wdata[8:0];
            else allow_dup_ff <= csr_wdata[0];
         end
         if (hwe) head_valid_ff[h_ff] <= hwd[NW];
         case (state_ff)
            S_INIT: begin
               init_ff <= init_ff + 1'b1;
               if (32'(init_ff) == NUM_NODES - 1) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  rem_ff   <= '0;
                  quo_ff   <= req_data.key;
                  step_ff  <= '0;
                  removed_ff <= '0;
                  status_ff  <= ST_OK;
                  found_ff   <= '0;
                  state_ff   <= S_DIV;
               end
            end
            S_DIV: begin
               if (!trial[32]) rem_ff <= trial[31:0];
               else rem_ff <= {rem_ff[30:0], quo_ff[31]};
               quo_ff  <= {quo_ff[30:0], 1'b0};
               step_ff <= step_ff + 1'b1;
               if (step_ff == 6'd31) state_ff <= S_HEAD;
            end
            S_HEAD: begin
               h_ff <= BW'(rem_ff);
               state_ff <= S_CHK;
               step_ff <= '0;
            end
            S_CHK: begin
               // step 0 waits for the registered head read; head_rd is valid at step 1
               if (step_ff == 6'd0) begin
                  step_ff <= 6'd1;
               end else begin
                  cur_ff       <= head_rd_ff[NW-1:0];
                  have_cur_ff  <= head_rd_ff[NW];
                  have_prev_ff <= 1'b0;
                  guard_ff     <= '0;
                  nd_ff        <= free_head_ff;
                  case (req_ff.operation)
                     OP_INSERT: begin
                        if (!free_valid_ff) begin
                           status_ff <= ST_FULL;
                           state_ff  <= S_OUT;
                        end else begin
                           free_valid_ff <= rd_link_ff[NW];
                           free_head_ff  <= rd_link_ff[NW-1:0];
                           state_ff <= allow_dup_ff ? S_WRN : S_RD;
                        end
                     end
                     OP_FIND, OP_DELETE: state_ff <= S_RD;
                     default: state_ff <= S_OUT;
                  endcase
                  step_ff <= 6'd2;
               end
            end
            S_RD: begin
               // address cur issued; wait for data
               if (!have_cur_ff || guard_ff == CW'(NUM_NODES)) begin
                  if (req_ff.operation == OP_INSERT) state_ff <= S_WRN;
                  else begin
                     if (req_ff.operation == OP_FIND) status_ff <= ST_NOTFOUND;
                     else if (removed_ff == '0) status_ff <= ST_NOTFOUND;
                     state_ff <= S_OUT;
                  end
               end else if (step_ff == 6'd2) begin
                  step_ff <= 6'd3;
               end else begin
                  step_ff <= 6'd2;
                  guard_ff <= guard_ff + 1'b1;
                  case (req_ff.operation)
                     OP_INSERT: begin
                        if (key_hit) begin
                           status_ff <= ST_DUP;
                           state_ff <= S_FREE;
                        end else if (rd_key_ff > req_ff.key) begin
                           state_ff <= S_WRN;
                        end else begin
                           prev_ff <= cur_ff; have_prev_ff <= 1'b1;
                           cur_ff <= rd_link_ff[NW-1:0];
                           have_cur_ff <= rd_link_ff[NW];
                        end
                     end
                     OP_FIND: begin
                        if (key_hit) begin
                           found_ff <= rd_val_ff;
                           state_ff <= S_OUT;
                        end else begin
                           cur_ff <= rd_link_ff[NW-1:0];
                           have_cur_ff <= rd_link_ff[NW];
                        end
                     end
                     default: begin
                        if (key_hit && dmatch) begin
                           state_ff <= S_WRP;
                        end else begin
                           prev_ff <= cur_ff; have_prev_ff <= 1'b1;
                           cur_ff <= rd_link_ff[NW-1:0];
                           have_cur_ff <= rd_link_ff[NW];
                        end
                     end
                  endcase
               end
            end
            S_WRN: begin
               if (req_ff.operation == OP_DELETE) begin
                  free_head_ff  <= nd_ff;
                  free_valid_ff <= 1'b1;
                  if (count_ff != '0) count_ff <= count_ff - 1'b1;
                  removed_ff <= removed_ff + 1'b1;
                  step_ff <= 6'd2;
                  state_ff <= S_RD;
               end else begin
                  count_ff <= count_ff + 1'b1;
                  state_ff <= S_WRP;
               end
            end
            S_WRP: begin
               if (req_ff.operation == OP_DELETE) begin
                  // unlinked node goes to nd, walk continues at its successor
                  nd_ff       <= cur_ff;
                  cur_ff      <= rd_link_ff[NW-1:0];
                  have_cur_ff <= rd_link_ff[NW];
                  state_ff    <= S_WRN;
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_FREE: begin
               free_head_ff  <= nd_ff;
               free_valid_ff <= 1'b1;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff) rsp_valid_ff <= 1'b1;
               else if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data.status        = status_ff;
   assign rsp_data.bucket        = 8'(h_ff);
   assign rsp_data.found_data    = found_ff;
   assign rsp_data.removed_count = 11'(removed_ff);
   assign rsp_data.entry_count   = 11'(count_ff);

   property p_idle_no_rsp;
      @(posedge clock) disable iff (reset) (state_ff == S_IDLE) |-> !rsp_valid_ff;
   endproperty
   assert property (p_idle_no_rsp) else $error("result shown while idle");

   property p_count_bound;
      @(posedge clock) disable iff (reset) 32'(count_ff) <= NUM_NODES;
   endproperty
   assert property (p_count_bound) else $error("entry count overflow");

   property p_rsp_holds;
      @(posedge clock) disable iff (reset)
         (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(status_ff));
   endproperty
   assert property (p_rsp_holds) else $error("result lost under stall");

endmodule
